[src/spi_pkg.sv]
// Shared types and constants for the segment pair intersection core.
`default_nettype none

package spi_pkg;

  // Field widths fixed by the payload format
  localparam int CoordBits = 24;
  localparam int OutBits   = 40;

  // Derived arithmetic widths
  localparam int DiffBits  = CoordBits + 1;       // coordinate difference
  localparam int ProdBits  = 2 * DiffBits;        // one product of differences
  localparam int CrossBits = 2 * CoordBits + 4;   // cross, dot and their sums
  localparam int NumBits   = 2 * CoordBits + 2;   // clamped numerator / denominator

  // Result count codes
  localparam logic [1:0] HitNone    = 2'd0;
  localparam logic [1:0] HitPoint   = 2'd1;
  localparam logic [1:0] HitOverlap = 2'd2;

  typedef struct packed {
    logic signed [CoordBits-1:0] a_start_x;
    logic signed [CoordBits-1:0] a_start_y;
    logic signed [CoordBits-1:0] a_end_x;
    logic signed [CoordBits-1:0] a_end_y;
    logic signed [CoordBits-1:0] b_start_x;
    logic signed [CoordBits-1:0] b_start_y;
    logic signed [CoordBits-1:0] b_end_x;
    logic signed [CoordBits-1:0] b_end_y;
    logic                        skip_endpoint_touch;
  } seg_in_t;

  typedef struct packed {
    logic        [1:0]         hit_count;
    logic signed [OutBits-1:0] first_x;
    logic signed [OutBits-1:0] first_y;
    logic signed [OutBits-1:0] second_x;
    logic signed [OutBits-1:0] second_y;
  } seg_out_t;

endpackage

`default_nettype wire

[src/segment_pair_intersection_core.sv]
// Top level of the pipelined segment pair intersection core.
//
// Usage: present two segments (a, b) with integer endpoints and the
// endpoint-touch flag as one beat on the in_ channel (valid/ready). One beat
// comes out on the out_ channel per input beat, in order: hit_count 0 (no
// contact), 1 (one point in first_x/first_y) or 2 (overlap ends in first_*
// and second_*), points in signed fixed point with FRAC_BITS fraction bits,
// unused points zero.
// The pipeline is five geometry stages followed by the coordinate lanes, whose
// restoring dividers retire one quotient bit per stage. Throughput: one beat per
// cycle while the receiver does not hold the output beat.
// The whole pipeline advances together; when the output beat is held by the
// receiver, in_ready drops and every stage holds, so nothing is lost.
// Reset (rst_n low, synchronous) empties the pipeline; payload registers
// are not cleared.
`default_nettype none

module segment_pair_intersection_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire spi_pkg::seg_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output spi_pkg::seg_out_t     out_data
);
  import spi_pkg::*;

  localparam int C        = CoordBits;
  localparam int D        = DiffBits;
  localparam int P        = CrossBits;
  localparam int N        = NumBits;
  localparam int LaneLat  = DiffBits + FRAC_BITS + 3;
  localparam int FrontLat = 5;
  localparam int TotalLat = FrontLat + LaneLat;

  logic adv;
  logic vld_r [TotalLat];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TotalLat; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < TotalLat; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Stage 1: direction vectors and offset between start points
  logic signed [C-1:0] s1_a1x_r, s1_a1y_r, s1_b1x_r, s1_b1y_r;
  logic signed [D-1:0] s1_vax_r, s1_vay_r, s1_vbx_r, s1_vby_r, s1_ex_r, s1_ey_r;
  logic                s1_skip_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a1x_r  <= in_data.a_start_x;
      s1_a1y_r  <= in_data.a_start_y;
      s1_b1x_r  <= in_data.b_start_x;
      s1_b1y_r  <= in_data.b_start_y;
      s1_vax_r  <= D'(in_data.a_end_x) - D'(in_data.a_start_x);
      s1_vay_r  <= D'(in_data.a_end_y) - D'(in_data.a_start_y);
      s1_vbx_r  <= D'(in_data.b_end_x) - D'(in_data.b_start_x);
      s1_vby_r  <= D'(in_data.b_end_y) - D'(in_data.b_start_y);
      s1_ex_r   <= D'(in_data.b_start_x) - D'(in_data.a_start_x);
      s1_ey_r   <= D'(in_data.b_start_y) - D'(in_data.a_start_y);
      s1_skip_r <= in_data.skip_endpoint_touch;
    end
  end

  // Stage 2: all products for the cross and dot terms
  logic signed [ProdBits-1:0] s2_p_r [12];
  logic signed [C-1:0] s2_a1x_r, s2_a1y_r, s2_b1x_r, s2_b1y_r;
  logic signed [D-1:0] s2_vax_r, s2_vay_r, s2_vbx_r, s2_vby_r;
  logic                s2_skip_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_p_r[0]  <= s1_vax_r * s1_vby_r;
      s2_p_r[1]  <= s1_vay_r * s1_vbx_r;
      s2_p_r[2]  <= s1_ex_r  * s1_vby_r;
      s2_p_r[3]  <= s1_ey_r  * s1_vbx_r;
      s2_p_r[4]  <= s1_ex_r  * s1_vay_r;
      s2_p_r[5]  <= s1_ey_r  * s1_vax_r;
      s2_p_r[6]  <= s1_vax_r * s1_vax_r;
      s2_p_r[7]  <= s1_vay_r * s1_vay_r;
      s2_p_r[8]  <= s1_vax_r * s1_ex_r;
      s2_p_r[9]  <= s1_vay_r * s1_ey_r;
      s2_p_r[10] <= s1_vax_r * s1_vbx_r;
      s2_p_r[11] <= s1_vay_r * s1_vby_r;
      s2_a1x_r   <= s1_a1x_r;
      s2_a1y_r   <= s1_a1y_r;
      s2_b1x_r   <= s1_b1x_r;
      s2_b1y_r   <= s1_b1y_r;
      s2_vax_r   <= s1_vax_r;
      s2_vay_r   <= s1_vay_r;
      s2_vbx_r   <= s1_vbx_r;
      s2_vby_r   <= s1_vby_r;
      s2_skip_r  <= s1_skip_r;
    end
  end

  // Stage 3: cross and dot products
  logic signed [P-1:0] s3_k_r, s3_sn_r, s3_tn_r, s3_len_r, s3_n1_r, s3_dvb_r;
  logic signed [C-1:0] s3_a1x_r, s3_a1y_r, s3_b1x_r, s3_b1y_r;
  logic signed [D-1:0] s3_vax_r, s3_vay_r, s3_vbx_r, s3_vby_r;
  logic                s3_skip_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_k_r    <= P'(s2_p_r[0]) - P'(s2_p_r[1]);
      s3_sn_r   <= P'(s2_p_r[2]) - P'(s2_p_r[3]);
      s3_tn_r   <= P'(s2_p_r[4]) - P'(s2_p_r[5]);
      s3_len_r  <= P'(s2_p_r[6]) + P'(s2_p_r[7]);
      s3_n1_r   <= P'(s2_p_r[8]) + P'(s2_p_r[9]);
      s3_dvb_r  <= P'(s2_p_r[10]) + P'(s2_p_r[11]);
      s3_a1x_r  <= s2_a1x_r;
      s3_a1y_r  <= s2_a1y_r;
      s3_b1x_r  <= s2_b1x_r;
      s3_b1y_r  <= s2_b1y_r;
      s3_vax_r  <= s2_vax_r;
      s3_vay_r  <= s2_vay_r;
      s3_vbx_r  <= s2_vbx_r;
      s3_vby_r  <= s2_vby_r;
      s3_skip_r <= s2_skip_r;
    end
  end

  // Stage 4: make the crossing denominator positive, order the overlap ends
  logic signed [P-1:0] n2;
  logic signed [P-1:0] s4_k_r, s4_sn_r, s4_tn_r, s4_len_r, s4_nmin_r, s4_nmax_r;
  logic signed [C-1:0] s4_a1x_r, s4_a1y_r, s4_b1x_r, s4_b1y_r;
  logic signed [D-1:0] s4_vax_r, s4_vay_r, s4_vbx_r, s4_vby_r;
  logic                s4_skip_r;

  assign n2 = s3_n1_r + s3_dvb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_k_r    <= s3_k_r[P-1] ? -s3_k_r  : s3_k_r;
      s4_sn_r   <= s3_k_r[P-1] ? -s3_sn_r : s3_sn_r;
      s4_tn_r   <= s3_k_r[P-1] ? -s3_tn_r : s3_tn_r;
      s4_len_r  <= s3_len_r;
      s4_nmin_r <= (n2 < s3_n1_r) ? n2 : s3_n1_r;
      s4_nmax_r <= (n2 < s3_n1_r) ? s3_n1_r : n2;
      s4_a1x_r  <= s3_a1x_r;
      s4_a1y_r  <= s3_a1y_r;
      s4_b1x_r  <= s3_b1x_r;
      s4_b1y_r  <= s3_b1y_r;
      s4_vax_r  <= s3_vax_r;
      s4_vay_r  <= s3_vay_r;
      s4_vbx_r  <= s3_vbx_r;
      s4_vby_r  <= s3_vby_r;
      s4_skip_r <= s3_skip_r;
    end
  end

  // Stage 5: classify the contact and set up the four coordinate lanes
  logic        [1:0]   hit_nxt;
  logic        [N-1:0] den_nxt;
  logic signed [C-1:0] base_nxt [4];
  logic        [N-1:0] num_nxt  [4];
  logic signed [D-1:0] vec_nxt  [4];
  logic signed [P-1:0] lo_clip, hi_clip;

  assign lo_clip = s4_nmin_r[P-1] ? '0 : s4_nmin_r;
  assign hi_clip = (s4_len_r < s4_nmax_r) ? s4_len_r : s4_nmax_r;

  always_comb begin
    hit_nxt = HitNone;
    den_nxt = N'(1);
    for (int i = 0; i < 4; i++) begin
      base_nxt[i] = '0;
      num_nxt[i]  = '0;
      vec_nxt[i]  = '0;
    end
    if (s4_k_r != '0) begin
      if (s4_sn_r[P-1] || s4_sn_r > s4_k_r || s4_tn_r[P-1] || s4_tn_r > s4_k_r) begin
        hit_nxt = HitNone;
      end else if (s4_sn_r == '0 || s4_sn_r == s4_k_r ||
                   !(s4_tn_r == '0 || s4_tn_r == s4_k_r)) begin
        // crossing inside both, or at an end of a: take the point along a
        if (!s4_skip_r || !(s4_sn_r == '0 || s4_sn_r == s4_k_r)) begin
          hit_nxt     = HitPoint;
          den_nxt     = s4_k_r[N-1:0];
          base_nxt[0] = s4_a1x_r;
          base_nxt[1] = s4_a1y_r;
          num_nxt[0]  = s4_sn_r[N-1:0];
          num_nxt[1]  = s4_sn_r[N-1:0];
          vec_nxt[0]  = s4_vax_r;
          vec_nxt[1]  = s4_vay_r;
        end
      end else if (!s4_skip_r) begin
        // crossing at an end of b only: take the point along b
        hit_nxt     = HitPoint;
        den_nxt     = s4_k_r[N-1:0];
        base_nxt[0] = s4_b1x_r;
        base_nxt[1] = s4_b1y_r;
        num_nxt[0]  = s4_tn_r[N-1:0];
        num_nxt[1]  = s4_tn_r[N-1:0];
        vec_nxt[0]  = s4_vbx_r;
        vec_nxt[1]  = s4_vby_r;
      end
    end else if (s4_len_r != '0 && s4_tn_r == '0 &&
                 !(s4_len_r < s4_nmin_r) && !s4_nmax_r[P-1]) begin
      den_nxt     = s4_len_r[N-1:0];
      base_nxt[0] = s4_a1x_r;
      base_nxt[1] = s4_a1y_r;
      vec_nxt[0]  = s4_vax_r;
      vec_nxt[1]  = s4_vay_r;
      if (s4_nmin_r == s4_len_r) begin
        // touch at the end of a
        if (!s4_skip_r) begin
          hit_nxt    = HitPoint;
          num_nxt[0] = s4_len_r[N-1:0];
          num_nxt[1] = s4_len_r[N-1:0];
        end
      end else if (s4_nmax_r == '0) begin
        // touch at the start of a
        if (!s4_skip_r) begin
          hit_nxt = HitPoint;
        end
      end else if (!(s4_skip_r && s4_nmin_r == '0 && s4_nmax_r == s4_len_r)) begin
        hit_nxt     = HitOverlap;
        num_nxt[0]  = lo_clip[N-1:0];
        num_nxt[1]  = lo_clip[N-1:0];
        num_nxt[2]  = hi_clip[N-1:0];
        num_nxt[3]  = hi_clip[N-1:0];
        base_nxt[2] = s4_a1x_r;
        base_nxt[3] = s4_a1y_r;
        vec_nxt[2]  = s4_vax_r;
        vec_nxt[3]  = s4_vay_r;
      end
      // drop the lanes again when nothing is reported
      if (hit_nxt == HitNone) begin
        den_nxt = N'(1);
        for (int i = 0; i < 4; i++) begin
          base_nxt[i] = '0;
          num_nxt[i]  = '0;
          vec_nxt[i]  = '0;
        end
      end
    end
  end

  logic        [1:0]   s5_hit_r;
  logic        [N-1:0] s5_den_r;
  logic signed [C-1:0] s5_base_r [4];
  logic        [N-1:0] s5_num_r  [4];
  logic signed [D-1:0] s5_vec_r  [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_hit_r <= hit_nxt;
      s5_den_r <= den_nxt;
      for (int i = 0; i < 4; i++) begin
        s5_base_r[i] <= base_nxt[i];
        s5_num_r[i]  <= num_nxt[i];
        s5_vec_r[i]  <= vec_nxt[i];
      end
    end
  end

  // Coordinate lanes: first_x, first_y, second_x, second_y
  logic [OutBits-1:0] lane_pt [4];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    spi_fixpt_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .en   (adv),
      .base (s5_base_r[g]),
      .num  (s5_num_r[g]),
      .den  (s5_den_r),
      .vec  (s5_vec_r[g]),
      .point(lane_pt[g])
    );
  end

  // Delay the count alongside the lanes
  logic [1:0] hit_r [LaneLat];

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r[0] <= s5_hit_r;
      for (int i = 1; i < LaneLat; i++) hit_r[i] <= hit_r[i-1];
    end
  end

  assign out_valid         = vld_r[TotalLat-1];
  assign out_data.hit_count = hit_r[LaneLat-1];
  assign out_data.first_x   = lane_pt[0];
  assign out_data.first_y   = lane_pt[1];
  assign out_data.second_x  = lane_pt[2];
  assign out_data.second_y  = lane_pt[3];

  // Checks on the result encoding
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hit_count != 2'd3)
    else $error("hit_count out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit_count == HitNone |->
      out_data.first_x == '0 && out_data.first_y == '0)
    else $error("first point not zero with no contact");

  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit_count != HitOverlap |->
      out_data.second_x == '0 && out_data.second_y == '0)
    else $error("second point not zero without overlap");

endmodule

`default_nettype wire

[src/spi_fixpt_lane.sv]
// One coordinate lane: base + round(num * vec / den) in fixed point, pipelined.
`default_nettype none

module spi_fixpt_lane #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [spi_pkg::CoordBits-1:0] base,
  input  wire logic        [spi_pkg::NumBits-1:0]   num,
  input  wire logic        [spi_pkg::NumBits-1:0]   den,
  input  wire logic signed [spi_pkg::DiffBits-1:0]  vec,
  output logic             [spi_pkg::OutBits-1:0]   point
);
  import spi_pkg::*;

  localparam int N = NumBits;
  localparam int V = DiffBits;
  localparam int H = (N + 1) / 2;               // low half of the numerator
  localparam int L = N - H;                     // high half of the numerator
  localparam int Q = V + FRAC_BITS;             // quotient bits
  localparam int W = N + V + FRAC_BITS;         // dividend bits
  localparam int X = (CoordBits + FRAC_BITS + 2 > OutBits) ?
                     (CoordBits + FRAC_BITS + 2) : OutBits;

  // Split multiply of the numerator by |vec|
  logic        [V-1:0]   av;
  logic        [L+V-1:0] ph_r;
  logic        [H+V-1:0] pl_r;
  logic        [N-1:0]   den1_r;
  logic signed [CoordBits-1:0] base1_r;
  logic                  neg1_r;

  assign av = vec[V-1] ? V'(-vec) : V'(vec);

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r    <= (L+V)'(num[N-1:H]) * (L+V)'(av);
      pl_r    <= (H+V)'(num[H-1:0]) * (H+V)'(av);
      den1_r  <= den;
      base1_r <= base;
      neg1_r  <= vec[V-1];
    end
  end

  // Divider stage arrays; index 0 holds the assembled dividend
  logic        [N-1:0]         rem_r  [Q];
  logic        [Q-1:0]         low_r  [Q];
  logic        [N-1:0]         dv_r   [Q];
  logic        [Q-1:0]         quo_r  [Q+1];
  logic signed [CoordBits-1:0] bs_r   [Q+1];
  logic                        ng_r   [Q+1];
  logic        [W-1:0]         prod;
  logic        [W-1:0]         dividend;

  // Assemble the product, scale it and add half the divisor for rounding
  assign prod     = (W'(ph_r) << H) + W'(pl_r);
  assign dividend = (prod << FRAC_BITS) + W'(den1_r >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= dividend[W-1:Q];
      low_r[0] <= dividend[Q-1:0];
      dv_r[0]  <= den1_r;
      quo_r[0] <= '0;
      bs_r[0]  <= base1_r;
      ng_r[0]  <= neg1_r;
    end
  end

  // Restoring division, one quotient bit per stage
  for (genvar j = 1; j <= Q; j++) begin : g_div
    logic [N+1:0] trial;
    logic         ge;

    assign trial = {1'b0, rem_r[j-1], low_r[j-1][Q-1]} - {2'b00, dv_r[j-1]};
    assign ge    = !trial[N+1];

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[j] <= {quo_r[j-1][Q-2:0], ge};
        bs_r[j]  <= bs_r[j-1];
        ng_r[j]  <= ng_r[j-1];
      end
    end

    if (j < Q) begin : g_carry
      logic [N:0] shifted;

      assign shifted = {rem_r[j-1], low_r[j-1][Q-1]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? trial[N-1:0] : shifted[N-1:0];
          low_r[j] <= low_r[j-1] << 1;
          dv_r[j]  <= dv_r[j-1];
        end
      end
    end
  end

  // Apply the signed offset to the scaled base point
  logic signed [X-1:0] base_fx;
  logic        [X-1:0] qx;
  logic        [X-1:0] sum;
  logic        [OutBits-1:0] point_r;

  assign base_fx = X'(bs_r[Q]) <<< FRAC_BITS;
  assign qx      = X'(quo_r[Q]);
  assign sum     = ng_r[Q] ? (base_fx - qx) : (base_fx + qx);

  always_ff @(posedge clk) begin
    if (en) begin
      point_r <= sum[OutBits-1:0];
    end
  end

  assign point = point_r;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Testbench for the segment pair intersection core: directed and random segment pairs.
`default_nettype none

module tb_top;
  import spi_pkg::*;

  localparam int FracBits   = 16;
  localparam int DrainWait  = 80;
  localparam int CycleLimit = 400000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  seg_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  seg_out_t out_data;

  seg_out_t expected_hits[$];
  int       mismatch_count;
  int       cycle_count;
  int       burst_left;
  int       stall_mode;

  segment_pair_intersection_core #(.FRAC_BITS(FracBits)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Clock: period 8
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Point = base + round(num/den * v) in fixed point, ties away from zero
  function automatic logic [OutBits-1:0] fix_point(longint base, longint num, longint den,
                                                   longint v);
    bit [127:0] av;
    bit [127:0] mag;
    bit [127:0] quo;
    longint     based;
    av = (v < 0) ? 128'(-v) : 128'(v);
    mag = (128'(num) * av) << FracBits;
    quo = (mag + 128'(den >>> 1)) / 128'(den);
    based = base <<< FracBits;
    based = (v < 0) ? based - longint'(quo[63:0]) : based + longint'(quo[63:0]);
    return based[OutBits-1:0];
  endfunction

  // Expected contact for one segment pair
  function automatic seg_out_t predict_contact(seg_in_t s);
    seg_out_t r;
    longint a1x, a1y, b1x, b1y, vax, vay, vbx, vby, ex, ey;
    longint k, sn, tn, len, n1, n2, nmin, nmax;
    r = '0;
    a1x = s.a_start_x; a1y = s.a_start_y;
    b1x = s.b_start_x; b1y = s.b_start_y;
    vax = longint'(s.a_end_x) - a1x; vay = longint'(s.a_end_y) - a1y;
    vbx = longint'(s.b_end_x) - b1x; vby = longint'(s.b_end_y) - b1y;
    ex = b1x - a1x; ey = b1y - a1y;
    k = vax * vby - vay * vbx;
    if (k != 0) begin
      sn = ex * vby - ey * vbx;
      tn = ex * vay - ey * vax;
      if (k < 0) begin
        k = -k; sn = -sn; tn = -tn;
      end
      if (sn < 0 || sn > k || tn < 0 || tn > k) return r;
      if (sn == 0 || sn == k) begin
        if (s.skip_endpoint_touch) return r;
        r.first_x = fix_point(a1x, sn, k, vax);
        r.first_y = fix_point(a1y, sn, k, vay);
      end else if (tn == 0 || tn == k) begin
        if (s.skip_endpoint_touch) return r;
        r.first_x = fix_point(b1x, tn, k, vbx);
        r.first_y = fix_point(b1y, tn, k, vby);
      end else begin
        r.first_x = fix_point(a1x, sn, k, vax);
        r.first_y = fix_point(a1y, sn, k, vay);
      end
      r.hit_count = HitPoint;
      return r;
    end
    len = vax * vax + vay * vay;
    if (len == 0) return r;
    if (ex * vay - ey * vax != 0) return r;
    n1 = vax * ex + vay * ey;
    n2 = n1 + vax * vbx + vay * vby;
    nmin = (n2 < n1) ? n2 : n1;
    nmax = (n2 < n1) ? n1 : n2;
    if (nmin > len || nmax < 0) return r;
    if (nmin == len || nmax == 0) begin
      if (s.skip_endpoint_touch) return r;
      r.hit_count = HitPoint;
      r.first_x = fix_point(a1x, (nmin == len) ? len : 0, len, vax);
      r.first_y = fix_point(a1y, (nmin == len) ? len : 0, len, vay);
      return r;
    end
    if (s.skip_endpoint_touch && nmin == 0 && nmax == len) return r;
    if (nmin < 0) nmin = 0;
    if (nmax > len) nmax = len;
    r.hit_count = HitOverlap;
    r.first_x  = fix_point(a1x, nmin, len, vax);
    r.first_y  = fix_point(a1y, nmin, len, vay);
    r.second_x = fix_point(a1x, nmax, len, vax);
    r.second_y = fix_point(a1y, nmax, len, vay);
    return r;
  endfunction

  // Record the expected contact of every accepted beat
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) expected_hits.push_back(predict_contact(in_data));
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    seg_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_hits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result beat: %p", out_data);
      end else begin
        want = expected_hits.pop_front();
        if (out_data.hit_count !== want.hit_count || out_data.first_x !== want.first_x ||
            out_data.first_y !== want.first_y || out_data.second_x !== want.second_x ||
            out_data.second_y !== want.second_y) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  // Receiver stalls: one of four random ready patterns
  always @(negedge clk) begin
    if (cycle_count % 150 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      2: out_ready <= ($urandom_range(0, 9) < 2);
      default: out_ready <= cycle_count[3];
    endcase
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Send one beat, with random bursts and gaps
  task automatic send_pair(seg_in_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic seg_in_t make_pair(longint ax, longint ay, longint bx, longint by,
                                        longint cx, longint cy, longint dx, longint dy,
                                        bit skip);
    seg_in_t s;
    s.a_start_x = ax[CoordBits-1:0]; s.a_start_y = ay[CoordBits-1:0];
    s.a_end_x   = bx[CoordBits-1:0]; s.a_end_y   = by[CoordBits-1:0];
    s.b_start_x = cx[CoordBits-1:0]; s.b_start_y = cy[CoordBits-1:0];
    s.b_end_x   = dx[CoordBits-1:0]; s.b_end_y   = dy[CoordBits-1:0];
    s.skip_endpoint_touch = skip;
    return s;
  endfunction

  function automatic longint rand_span(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Extremes and named corner cases
  task automatic test_directed();
    longint mx, mn;
    bit     sk;
    mx = 8388607; mn = -8388608;
    for (int skip = 0; skip < 2; skip++) begin
      sk = 1'(skip);
      send_pair(make_pair(mn, mn, mx, mx, mn, mx, mx, mn, sk));   // full-range diagonals
      send_pair(make_pair(5, 5, 5, 5, 0, 0, 10, 10, sk));         // zero-length a
      send_pair(make_pair(0, 0, 10, 0, 4, 0, 4, 0, sk));          // point b inside a
      send_pair(make_pair(0, 0, 10, 0, 10, -5, 10, 5, sk));       // cross at end of a
      send_pair(make_pair(0, 0, 10, 0, 3, 0, 3, 7, sk));          // cross at start of b
      send_pair(make_pair(0, 0, 10, 0, 10, 0, 20, 0, sk));        // collinear end touch
      send_pair(make_pair(0, 0, 10, 0, -5, 0, 0, 0, sk));         // collinear start touch
      send_pair(make_pair(0, 0, 10, 4, 10, 4, 0, 0, sk));         // b covers exactly a
      send_pair(make_pair(0, 0, 10, 0, 0, 1, 10, 1, sk));         // parallel, apart
      send_pair(make_pair(0, 0, 9, 3, 12, 4, -3, -1, sk));        // overlap both ways
      send_pair(make_pair(0, 0, 7, 3, 0, 3, 7, 0, sk));           // plain crossing
      send_pair(make_pair(mx, mn, mn, mx, mn, mn, mx, mx, sk));   // extremes reversed
    end
  endtask

  // Random segment pairs, mostly in a small box
  task automatic test_crossings(int count);
    int span;
    for (int i = 0; i < count; i++) begin
      span = ($urandom_range(0, 3) == 0) ? 8000000 : 64;
      send_pair(make_pair(rand_span(span), rand_span(span), rand_span(span), rand_span(span),
                          rand_span(span), rand_span(span), rand_span(span), rand_span(span),
                          1'($urandom_range(0, 1))));
    end
  endtask

  // Random collinear pairs on one line
  task automatic test_collinear(int count);
    longint px, py, dx, dy;
    longint m[4];
    for (int i = 0; i < count; i++) begin
      px = rand_span(1 << 20); py = rand_span(1 << 20);
      dx = rand_span(1000); dy = rand_span(1000);
      foreach (m[j]) m[j] = rand_span(12);
      if ($urandom_range(0, 3) == 0) m[2] = m[$urandom_range(0, 1)];
      if ($urandom_range(0, 5) == 0) m[3] = m[2];
      send_pair(make_pair(px + m[0] * dx, py + m[0] * dy, px + m[1] * dx, py + m[1] * dy,
                          px + m[2] * dx, py + m[2] * dy, px + m[3] * dx, py + m[3] * dy,
                          1'($urandom_range(0, 1))));
    end
  endtask

  // Segment b starting or ending on an endpoint of a
  task automatic test_endpoint_touch(int count);
    longint ax, ay, bx, by, cx, cy;
    for (int i = 0; i < count; i++) begin
      ax = rand_span(1 << 22); ay = rand_span(1 << 22);
      bx = ax + rand_span(5000); by = ay + rand_span(5000);
      cx = ax + rand_span(5000); cy = ay + rand_span(5000);
      if ($urandom_range(0, 1) == 0)
        send_pair(make_pair(ax, ay, bx, by, bx, by, cx, cy, 1'($urandom_range(0, 1))));
      else
        send_pair(make_pair(ax, ay, bx, by, cx, cy, ax, ay, 1'($urandom_range(0, 1))));
    end
  endtask

  // Fully random bits in every field
  task automatic test_noise(int count);
    seg_in_t      s;
    logic [223:0] raw;
    for (int i = 0; i < count; i++) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      s = raw[$bits(seg_in_t)-1:0];
      send_pair(s);
    end
  endtask

  initial begin
    int drain;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    stall_mode = 0;
    cycle_count = 0;
    mismatch_count = 0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_crossings(480);
    test_collinear(430);
    test_endpoint_touch(180);
    test_noise(200);
    @(negedge clk);
    in_valid <= 1'b0;
    // drain the pipeline
    while (expected_hits.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < DrainWait) begin
      @(posedge clk);
      drain++;
    end
    if (mismatch_count == 0 && expected_hits.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
